[sv/fee_pkg.sv]
// Shared types and constants of the flash EEPROM emulator.
// No dependencies; every file but fee_if and fee_ram imports this package.
`default_nettype none
package fee_pkg;

  typedef enum logic [2:0] {
    OP_RD8   = 3'd0,
    OP_RD16  = 3'd1,
    OP_RDBIT = 3'd2,
    OP_WR8   = 3'd3,
    OP_WR16  = 3'd4,
    OP_WRBIT = 3'd5,
    OP_START = 3'd6,
    OP_RECW  = 3'd7
  } op_e;

  typedef enum logic [1:0] {
    KIND_READ = 2'd0,
    KIND_PROG = 2'd1,
    KIND_DONE = 2'd2
  } kind_e;

  localparam logic [15:0] HDR_TAG    = 16'hBEE7;
  localparam logic [31:0] BASE_RESET = 32'h0800_F800;
  localparam logic [16:0] SEQ_NONE   = 17'h1_FFFF;

  // Decoded command handed from the front end to the back end
  typedef struct packed {
    op_e         op;
    logic [7:0]  addr;       // raw address field
    logic [7:0]  byte_addr;  // byte touched by byte and bit ops
    logic [15:0] wdata;
    logic [2:0]  slot;
    logic [31:0] fdata;
    logic        fin;
    logic        skip;       // out of range: fixed answer or ignored word
  } cmd_t;

endpackage
`default_nettype wire

[sv/fee_if.sv]
// Valid/ready channel interfaces of the flash EEPROM emulator.
// No dependencies.
`default_nettype none
interface fee_in_if;
  logic        valid;
  logic        ready;
  logic [2:0]  op;
  logic [7:0]  addr;
  logic [15:0] wdata;
  logic [2:0]  slot;
  logic [31:0] flash_data;
  logic        final_req;

  modport source (output valid, op, addr, wdata, slot, flash_data, final_req, input ready);
  modport sink   (input valid, op, addr, wdata, slot, flash_data, final_req, output ready);
endinterface

interface fee_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  kind;
  logic [15:0] read_data;
  logic [31:0] flash_addr;
  logic [31:0] page_word;
  logic        erase_first;
  logic        last;

  modport source (output valid, kind, read_data, flash_addr, page_word, erase_first, last,
                  input ready);
  modport sink   (input valid, kind, read_data, flash_addr, page_word, erase_first, last,
                  output ready);
endinterface
`default_nettype wire

[sv/flash_eeprom_emulator.sv]
// Top level of the flash EEPROM emulator: front end, command queue, back end.
// Depends on fee_pkg, fee_if, fee_front, fee_queue, fee_back (and fee_ram).
//
//   channel   dir  handshake          word
//   in_i      in   valid/ready        op, addr, wdata, slot, flash_data, final_req
//   out_o     out  valid/ready        kind, read_data, flash_addr, page_word,
//                                     erase_first, last
//   cfg       in   cfg_we_i (no wait) cfg_wdata_i = store_base_address
//
// Flow: the front end takes one word per cycle into a two-entry queue while the
// queue is not full; the back end works one command at a time. A read passes
// S_RA, S_RB, S_RC (16-bit reads only) and S_ROUT; an out-of-range read goes
// straight to S_ROUT. A recovery word passes S_REC, then S_CP to copy the
// NW = ceil(DATA_BYTES/4) staging words into the shadow when a record wins, then
// S_FIN when it reports. A write runs read-modify-write in S_WA/S_WB per byte,
// then commits the page in S_CI and an S_CR/S_CE pair per word (one shadow port).
// Reset: valid bits mark the shadow erased at once, so no clearing pass runs.
// Stalls: the output register holds a word while out_o.ready is low; the queue
// parts the input side, which stalls only when both queue entries are taken.
`default_nettype none
module flash_eeprom_emulator #(
  parameter int DATA_BYTES      = 240,
  parameter int SLOT_TOTAL      = 8,
  parameter int PAGE_SIZE_BYTES = 256,
  parameter int BOOL_LAST_BIT   = 100
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        cfg_we_i,
  input  wire logic [31:0] cfg_wdata_i,
  fee_in_if.sink           in_i,
  fee_out_if.source        out_o
);
  import fee_pkg::*;

  // Decoded commands between the two halves
  logic q_push, q_full, q_pop, q_vld;
  cmd_t q_in, q_head;

  // Classify and range-check each incoming word
  fee_front #(
    .DATA_BYTES(DATA_BYTES), .SLOT_TOTAL(SLOT_TOTAL), .BOOL_LAST_BIT(BOOL_LAST_BIT)
  ) u_front (
    .in_i, .q_full_i(q_full), .q_push_o(q_push), .q_cmd_o(q_in)
  );

  // Hold up to two commands so each side can stall on its own
  fee_queue u_queue (
    .clk_i, .rst_ni, .push_i(q_push), .push_cmd_i(q_in), .full_o(q_full),
    .pop_i(q_pop), .vld_o(q_vld), .head_o(q_head)
  );

  // Carry out reads, writes with their commit, and the recovery scan
  fee_back #(
    .DATA_BYTES(DATA_BYTES), .SLOT_TOTAL(SLOT_TOTAL), .PAGE_SIZE_BYTES(PAGE_SIZE_BYTES)
  ) u_back (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_wdata_i,
    .q_vld_i(q_vld), .q_cmd_i(q_head), .q_pop_o(q_pop), .out_o
  );
endmodule
`default_nettype wire

[sv/fee_ram.sv]
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none
module fee_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 60
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);
  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;
endmodule
`default_nettype wire

[sv/fee_front.sv]
// Front end: accepts input words, range-checks and decodes them into commands.
// Depends on fee_pkg and fee_in_if.
`default_nettype none
module fee_front #(
  parameter int DATA_BYTES    = 240,
  parameter int SLOT_TOTAL    = 8,
  parameter int BOOL_LAST_BIT = 100
) (
  fee_in_if.sink         in_i,
  input  wire logic      q_full_i,
  output logic           q_push_o,
  output fee_pkg::cmd_t  q_cmd_o
);
  import fee_pkg::*;

  localparam int CloseIdx = 1 + (DATA_BYTES + 3) / 4;

  op_e  op;
  logic bit_ok;
  logic skip;
  logic is_write;

  assign in_i.ready = !q_full_i;
  assign op         = op_e'(in_i.op);
  assign bit_ok     = (32'(in_i.addr) <= 32'(BOOL_LAST_BIT)) &&
                      (32'(in_i.addr[7:3]) < 32'(DATA_BYTES));

  always_comb begin
    is_write = 1'b0;
    unique case (op)
      OP_RD8:   skip = 32'(in_i.addr) >= 32'(DATA_BYTES);
      OP_RD16:  skip = 32'(in_i.addr) + 32'd2 > 32'(DATA_BYTES);
      OP_RDBIT: skip = !bit_ok;
      OP_WR8: begin
        skip     = 32'(in_i.addr) >= 32'(DATA_BYTES);
        is_write = 1'b1;
      end
      OP_WR16: begin
        skip     = 32'(in_i.addr) + 32'd2 > 32'(DATA_BYTES);
        is_write = 1'b1;
      end
      OP_WRBIT: begin
        skip     = !bit_ok;
        is_write = 1'b1;
      end
      OP_START: skip = 1'b0;
      OP_RECW:  skip = (32'(in_i.slot) >= 32'(SLOT_TOTAL)) ||
                       (32'(in_i.addr) > 32'(CloseIdx));
      default:  skip = 1'b1;
    endcase
  end

  // Drop out-of-range writes here: they cause nothing downstream
  assign q_push_o = in_i.valid && in_i.ready && !(is_write && skip);

  always_comb begin
    q_cmd_o.op        = op;
    q_cmd_o.addr      = in_i.addr;
    q_cmd_o.byte_addr = (op == OP_RDBIT || op == OP_WRBIT) ? {3'b000, in_i.addr[7:3]}
                                                           : in_i.addr;
    q_cmd_o.wdata     = in_i.wdata;
    q_cmd_o.slot      = in_i.slot;
    q_cmd_o.fdata     = in_i.flash_data;
    q_cmd_o.fin       = in_i.final_req;
    q_cmd_o.skip      = skip;
  end
endmodule
`default_nettype wire

[sv/fee_queue.sv]
// Two-entry command queue between front end and back end.
// Depends on fee_pkg.
`default_nettype none
module fee_queue (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           push_i,
  input  fee_pkg::cmd_t       push_cmd_i,
  output logic                full_o,
  input  wire logic           pop_i,
  output logic                vld_o,
  output fee_pkg::cmd_t       head_o
);
  import fee_pkg::*;

  cmd_t       ent_q [2];
  logic       wp_q, rp_q;
  logic [1:0] cnt_q;

  assign full_o = cnt_q == 2'd2;
  assign vld_o  = cnt_q != 2'd0;
  assign head_o = ent_q[rp_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      ent_q[wp_q] <= push_cmd_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= 1'b0;
      rp_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      if (push_i) wp_q <= ~wp_q;
      if (pop_i)  rp_q <= ~rp_q;
      cnt_q <= cnt_q + {1'b0, push_i} - {1'b0, pop_i};
    end
  end
endmodule
`default_nettype wire

[sv/fee_back.sv]
// Back end: shadow/staging stores, page commit, recovery scan and result register.
// Depends on fee_pkg, fee_out_if and fee_ram.
`default_nettype none
module fee_back #(
  parameter int DATA_BYTES      = 240,
  parameter int SLOT_TOTAL      = 8,
  parameter int PAGE_SIZE_BYTES = 256
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        cfg_we_i,
  input  wire logic [31:0] cfg_wdata_i,
  input  wire logic        q_vld_i,
  input  fee_pkg::cmd_t    q_cmd_i,
  output logic             q_pop_o,
  fee_out_if.source        out_o
);
  import fee_pkg::*;

  localparam int NW       = (DATA_BYTES + 3) / 4;
  localparam int AW       = $clog2(NW);
  localparam int NPW      = PAGE_SIZE_BYTES / 4;
  localparam int WIW      = $clog2(NPW);
  localparam int KW       = $clog2(NW + 1);
  localparam int LSW      = $clog2(SLOT_TOTAL);
  localparam int CloseIdx = 1 + NW;
  localparam logic [15:0] SumInit = 16'((DATA_BYTES * 255) % 65536);

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_RA   = 4'd1;
  localparam logic [3:0] S_RB   = 4'd2;
  localparam logic [3:0] S_RC   = 4'd3;
  localparam logic [3:0] S_ROUT = 4'd4;
  localparam logic [3:0] S_WA   = 4'd5;
  localparam logic [3:0] S_WB   = 4'd6;
  localparam logic [3:0] S_CI   = 4'd7;
  localparam logic [3:0] S_CR   = 4'd8;
  localparam logic [3:0] S_CE   = 4'd9;
  localparam logic [3:0] S_REC  = 4'd10;
  localparam logic [3:0] S_CP   = 4'd11;
  localparam logic [3:0] S_FIN  = 4'd12;

  // Sum of the bytes of one store word that lie inside the store
  function automatic logic [15:0] word_sum(input logic [31:0] w, input logic [7:0] wix);
    logic [15:0] s;
    s = 16'd0;
    for (int b = 0; b < 4; b++) begin
      if (32'(wix) * 32'd4 + 32'(b) < 32'(DATA_BYTES)) s = s + {8'd0, w[8*b +: 8]};
    end
    return s;
  endfunction

  // Bytes past the store read as erased flash
  function automatic logic [31:0] word_fill(input logic [31:0] w, input logic [7:0] wix);
    logic [31:0] r;
    r = w;
    for (int b = 0; b < 4; b++) begin
      if (32'(wix) * 32'd4 + 32'(b) >= 32'(DATA_BYTES)) r[8*b +: 8] = 8'hFF;
    end
    return r;
  endfunction

  logic [3:0]     state_q, state_d;
  cmd_t           cmd_q, cmd_d;
  logic           second_q, second_d;
  logic [15:0]    rdat_q, rdat_d;
  logic [7:0]     rlo_q, rlo_d;
  logic [WIW-1:0] wi_q, wi_d;
  logic [KW-1:0]  k_q, k_d;
  logic [15:0]    seq_q, seq_d;
  logic [LSW-1:0] live_q, live_d;
  logic [16:0]    best_q, best_d;
  logic           cmag_q, cmag_d;
  logic [15:0]    cseq_q, cseq_d;
  logic [15:0]    csum_q, csum_d;
  logic [15:0]    crun_q, crun_d;
  logic [15:0]    sum_q, sum_d;
  logic [31:0]    base_q;
  logic [31:0]    pbase_q, pbase_d;
  logic [NW-1:0]  vld_q, vld_d;
  logic           vrd_q;

  logic        sh_we, sh_re, st_we, st_re;
  logic [AW-1:0] sh_waddr, sh_raddr, st_waddr, st_raddr;
  logic [31:0] sh_wdata, sh_rdata, st_rdata, sh_word;

  logic        ov_q;
  logic [1:0]  ok_q;
  logic [15:0] ord_q;
  logic [31:0] ofa_q, opw_q;
  logic        oer_q, olast_q;
  logic        ld;
  kind_e       lk;
  logic [15:0] lrd;
  logic [31:0] lfa, lpw;
  logic        ler, llast;
  logic        free;

  // Scratch values of the combinational block
  logic [7:0]     ba1, wba, oldb, newb, lo, wix;
  logic [31:0]    nword;
  logic [LSW-1:0] live_nxt;
  logic [15:0]    run_nxt;
  logic           accept;

  fee_ram #(.WIDTH(32), .DEPTH(NW)) u_shadow (
    .clk_i, .we_i(sh_we), .waddr_i(sh_waddr), .wdata_i(sh_wdata),
    .re_i(sh_re), .raddr_i(sh_raddr), .rdata_o(sh_rdata)
  );

  fee_ram #(.WIDTH(32), .DEPTH(NW)) u_staging (
    .clk_i, .we_i(st_we), .waddr_i(st_waddr), .wdata_i(cmd_q.fdata),
    .re_i(st_re), .raddr_i(st_raddr), .rdata_o(st_rdata)
  );

  assign sh_word = vrd_q ? sh_rdata : 32'hFFFF_FFFF;
  assign free    = !ov_q || out_o.ready;

  always_comb begin
    state_d = state_q;  cmd_d = cmd_q;    second_d = second_q;
    rdat_d = rdat_q;    rlo_d = rlo_q;    wi_d = wi_q;     k_d = k_q;
    seq_d = seq_q;      live_d = live_q;  best_d = best_q;
    cmag_d = cmag_q;    cseq_d = cseq_q;  csum_d = csum_q; crun_d = crun_q;
    sum_d = sum_q;      pbase_d = pbase_q; vld_d = vld_q;
    q_pop_o = 1'b0;
    sh_we = 1'b0; sh_waddr = '0; sh_wdata = '0; sh_re = 1'b0; sh_raddr = '0;
    st_we = 1'b0; st_waddr = '0; st_re = 1'b0; st_raddr = '0;
    ld = 1'b0; lk = KIND_READ; lrd = '0; lfa = '0; lpw = '0; ler = 1'b0; llast = 1'b1;
    ba1 = cmd_q.byte_addr + 8'd1;
    wba = cmd_q.byte_addr + {7'd0, second_q};
    oldb = sh_word[8*wba[1:0] +: 8];
    lo = sh_word[8*cmd_q.byte_addr[1:0] +: 8];
    newb = oldb;
    nword = sh_word;
    wix = 8'(wi_q) - 8'd2;
    live_nxt = (32'(live_q) == 32'(SLOT_TOTAL - 1)) ? '0 : live_q + 1'b1;
    run_nxt = crun_q;
    accept = 1'b0;

    unique case (state_q)
      S_IDLE: begin
        if (q_vld_i) begin
          q_pop_o  = 1'b1;
          cmd_d    = q_cmd_i;
          second_d = 1'b0;
          case (q_cmd_i.op) inside
            OP_RD8, OP_RD16, OP_RDBIT: begin
              if (q_cmd_i.skip) begin
                rdat_d  = (q_cmd_i.op == OP_RD8)  ? 16'h00FF :
                          (q_cmd_i.op == OP_RD16) ? 16'hFFFF : 16'h0000;
                state_d = S_ROUT;
              end else begin
                state_d = S_RA;
              end
            end
            OP_WR8, OP_WR16, OP_WRBIT: state_d = S_WA;
            default:                   state_d = S_REC;
          endcase
        end
      end
      S_RA: begin
        sh_re    = 1'b1;
        sh_raddr = cmd_q.byte_addr[AW+1:2];
        state_d  = S_RB;
      end
      S_RB: begin
        rlo_d = lo;
        if (cmd_q.op == OP_RD16) begin
          sh_re    = 1'b1;
          sh_raddr = ba1[AW+1:2];
          state_d  = S_RC;
        end else begin
          rdat_d  = (cmd_q.op == OP_RDBIT) ? {15'd0, lo[cmd_q.addr[2:0]]} : {8'd0, lo};
          state_d = S_ROUT;
        end
      end
      S_RC: begin
        rdat_d  = {sh_word[8*ba1[1:0] +: 8], rlo_q};
        state_d = S_ROUT;
      end
      S_ROUT: begin
        if (free) begin
          ld      = 1'b1;
          lrd     = rdat_q;
          state_d = S_IDLE;
        end
      end
      S_WA: begin
        sh_re    = 1'b1;
        sh_raddr = wba[AW+1:2];
        state_d  = S_WB;
      end
      S_WB: begin
        case (cmd_q.op)
          OP_WRBIT: newb = cmd_q.wdata[0] ? (oldb | (8'd1 << cmd_q.addr[2:0]))
                                          : (oldb & ~(8'd1 << cmd_q.addr[2:0]));
          OP_WR16:  newb = second_q ? cmd_q.wdata[15:8] : cmd_q.wdata[7:0];
          default:  newb = cmd_q.wdata[7:0];
        endcase
        nword[8*wba[1:0] +: 8] = newb;
        sh_we    = 1'b1;
        sh_waddr = wba[AW+1:2];
        sh_wdata = nword;
        vld_d[wba[AW+1:2]] = 1'b1;
        sum_d    = sum_q + {8'd0, newb} - {8'd0, oldb};
        if (cmd_q.op == OP_WR16 && !second_q) begin
          second_d = 1'b1;
          state_d  = S_WA;
        end else begin
          state_d = S_CI;
        end
      end
      S_CI: begin
        seq_d   = seq_q + 16'd1;
        live_d  = live_nxt;
        pbase_d = base_q + 32'(live_nxt) * 32'(PAGE_SIZE_BYTES);
        wi_d    = '0;
        state_d = S_CR;
      end
      S_CR: begin
        if (32'(wi_q) >= 32'd2 && 32'(wix) < 32'(NW)) begin
          sh_re    = 1'b1;
          sh_raddr = wix[AW-1:0];
        end
        state_d = S_CE;
      end
      S_CE: begin
        if (free) begin
          ld    = 1'b1;
          lk    = KIND_PROG;
          lfa   = pbase_q + 32'({wi_q, 2'b00});
          ler   = wi_q == '0;
          llast = 32'(wi_q) == 32'(NPW - 1);
          if (wi_q == '0)                   lpw = {seq_q, HDR_TAG};
          else if (32'(wi_q) == 32'd1)      lpw = {16'd0, sum_q};
          else if (32'(wix) < 32'(NW))      lpw = word_fill(sh_word, wix);
          else                              lpw = 32'hFFFF_FFFF;
          if (llast) state_d = S_IDLE;
          else begin
            wi_d    = wi_q + 1'b1;
            state_d = S_CR;
          end
        end
      end
      S_REC: begin
        state_d = cmd_q.fin ? S_FIN : S_IDLE;
        if (cmd_q.op == OP_START) begin
          vld_d   = '0;
          sum_d   = SumInit;
          seq_d   = '0;
          live_d  = LSW'(SLOT_TOTAL - 1);
          best_d  = SEQ_NONE;
          cmag_d  = 1'b0;
          cseq_d  = '0;
          csum_d  = '0;
          crun_d  = '0;
          state_d = S_IDLE;
        end else if (!cmd_q.skip) begin
          if (cmd_q.addr == 8'd0) begin
            cmag_d = cmd_q.fdata[15:0] == HDR_TAG;
            cseq_d = cmd_q.fdata[31:16];
            crun_d = '0;
          end else if (cmd_q.addr == 8'd1) begin
            csum_d = cmd_q.fdata[15:0];
          end else begin
            st_we    = 1'b1;
            st_waddr = AW'(cmd_q.addr - 8'd2);
            run_nxt  = crun_q + word_sum(cmd_q.fdata, cmd_q.addr - 8'd2);
            crun_d   = run_nxt;
          end
          accept = (32'(cmd_q.addr) == 32'(CloseIdx)) && cmag_q && (csum_q == run_nxt) &&
                   (best_q == SEQ_NONE || {1'b0, cseq_q} > best_q);
          if (accept) begin
            best_d  = {1'b0, cseq_q};
            live_d  = LSW'(cmd_q.slot);
            seq_d   = cseq_q;
            sum_d   = '0;
            k_d     = '0;
            state_d = S_CP;
          end
        end
      end
      S_CP: begin
        // Read staging word k while writing word k-1 into the shadow
        if (32'(k_q) < 32'(NW)) begin
          st_re    = 1'b1;
          st_raddr = AW'(k_q);
        end
        if (k_q != '0) begin
          sh_we    = 1'b1;
          sh_waddr = AW'(k_q - 1'b1);
          sh_wdata = st_rdata;
          vld_d[AW'(k_q - 1'b1)] = 1'b1;
          sum_d    = sum_q + word_sum(st_rdata, 8'(k_q - 1'b1));
        end
        if (32'(k_q) == 32'(NW)) state_d = cmd_q.fin ? S_FIN : S_IDLE;
        else                     k_d = k_q + 1'b1;
      end
      S_FIN: begin
        if (free) begin
          ld      = 1'b1;
          lk      = KIND_DONE;
          lrd     = {15'd0, best_q != SEQ_NONE};
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      seq_q   <= '0;
      live_q  <= LSW'(SLOT_TOTAL - 1);
      best_q  <= SEQ_NONE;
      cmag_q  <= 1'b0;
      cseq_q  <= '0;
      csum_q  <= '0;
      crun_q  <= '0;
      sum_q   <= SumInit;
      base_q  <= BASE_RESET;
      vld_q   <= '0;
      ov_q    <= 1'b0;
    end else begin
      state_q <= state_d;
      seq_q   <= seq_d;
      live_q  <= live_d;
      best_q  <= best_d;
      cmag_q  <= cmag_d;
      cseq_q  <= cseq_d;
      csum_q  <= csum_d;
      crun_q  <= crun_d;
      sum_q   <= sum_d;
      vld_q   <= vld_d;
      if (cfg_we_i) base_q <= cfg_wdata_i;
      if (ld)                ov_q <= 1'b1;
      else if (out_o.ready)  ov_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    cmd_q    <= cmd_d;
    second_q <= second_d;
    rdat_q   <= rdat_d;
    rlo_q    <= rlo_d;
    wi_q     <= wi_d;
    k_q      <= k_d;
    pbase_q  <= pbase_d;
    if (sh_re) vrd_q <= vld_q[sh_raddr];
    if (ld) begin
      ok_q    <= lk;
      ord_q   <= lrd;
      ofa_q   <= lfa;
      opw_q   <= lpw;
      oer_q   <= ler;
      olast_q <= llast;
    end
  end

  assign out_o.valid       = ov_q;
  assign out_o.kind        = ok_q;
  assign out_o.read_data   = ord_q;
  assign out_o.flash_addr  = ofa_q;
  assign out_o.page_word   = opw_q;
  assign out_o.erase_first = oer_q;
  assign out_o.last        = olast_q;
endmodule
`default_nettype wire

[tb/sv/flash_eeprom_emulator_tb.sv]
// Self-checking testbench of the flash EEPROM emulator: reads, writes with page
// commits, recovery scans and base address changes, checked word by word.
// Depends on fee_pkg, fee_if and the flash_eeprom_emulator top level.
`timescale 1ns / 100ps
module flash_eeprom_emulator_tb;
  import fee_pkg::*;

  localparam int DATA_BYTES  = 240;
  localparam int SLOT_TOTAL  = 8;
  localparam int PG_SIZE     = 256;
  localparam int LAST_BIT    = 100;
  localparam int PAGE_WORDS  = PG_SIZE / 4;
  localparam int CLOSE_IDX   = 1 + (DATA_BYTES + 3) / 4;
  localparam int SETTLE      = 150;   // covers a winning record's staging copy
  localparam int STALL_LIMIT = 4000;

  typedef enum logic [1:0] {P_ITEM, P_CFG, P_DRAIN} pend_kind_e;

  typedef struct {
    pend_kind_e  what;
    op_e         op;
    logic [7:0]  addr;
    logic [15:0] wdata;
    logic [2:0]  slot;
    logic [31:0] fdata;
    logic        fin;
    logic [31:0] cfg;
  } pend_t;

  typedef struct {
    kind_e       kind;
    logic [15:0] rd;
    logic [31:0] fa;
    logic [31:0] pw;
    logic        er;
    logic        last;
  } result_t;

  logic        clk_i;
  logic        rst_ni;
  logic        cfg_we_i;
  logic [31:0] cfg_wdata_i;

  fee_in_if  in_if ();
  fee_out_if out_if ();

  flash_eeprom_emulator dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_wdata_i(cfg_wdata_i),
    .in_i       (in_if.sink),
    .out_o      (out_if.source)
  );

  // Mirror of the block's state
  logic [7:0]  shadow [DATA_BYTES];
  logic [7:0]  staging [DATA_BYTES];
  logic [15:0] commit_seq;
  logic [2:0]  live_slot;
  logic [16:0] best_seq;
  logic        cand_magic_ok;
  logic [15:0] cand_seq;
  logic [15:0] cand_stored_sum;
  logic [15:0] cand_run_sum;
  logic [31:0] base_addr;

  pend_t   pend_q[$];
  result_t expected_q[$];

  int  errors = 0;
  int  out_cnt = 0;
  int  quiet_cnt = 0;
  int  stall_cnt = 0;
  int  send_gap = 0;
  int  recv_gap = 0;
  int  long_hold = 0;
  bit  held_once = 0;
  bit  calm = 0;
  logic in_took;

  // ---------------------------------------------------------------- predictor
  task automatic push_result(kind_e k, logic [15:0] rd, logic [31:0] fa, logic [31:0] pw,
                             logic er, logic lst);
    result_t r;
    r.kind = k; r.rd = rd; r.fa = fa; r.pw = pw; r.er = er; r.last = lst;
    expected_q.push_back(r);
  endtask

  task automatic clear_store();
    foreach (shadow[i]) shadow[i] = 8'hFF;
    commit_seq      = '0;
    live_slot       = 3'(SLOT_TOTAL - 1);
    best_seq        = SEQ_NONE;
    cand_magic_ok   = 1'b0;
    cand_seq        = '0;
    cand_stored_sum = '0;
    cand_run_sum    = '0;
  endtask

  function automatic logic [7:0] page_byte(int i, logic [15:0] sum);
    case (i)
      0: return HDR_TAG[7:0];
      1: return HDR_TAG[15:8];
      2: return commit_seq[7:0];
      3: return commit_seq[15:8];
      4: return sum[7:0];
      5: return sum[15:8];
      6, 7: return 8'h00;
      default: return (i - 8 < DATA_BYTES) ? shadow[i - 8] : 8'hFF;
    endcase
  endfunction

  // Emit the next slot's page: header, data, fill; erase on the first word
  task automatic program_page();
    logic [2:0]  slot;
    logic [15:0] sum;
    logic [31:0] w;
    logic [31:0] addr;
    slot = 3'((live_slot + 1) % SLOT_TOTAL);
    addr = base_addr + 32'(slot) * PG_SIZE;
    commit_seq = commit_seq + 16'd1;
    sum = '0;
    foreach (shadow[i]) sum = sum + 16'(shadow[i]);
    for (int i = 0; i < PAGE_WORDS; i++) begin
      for (int b = 0; b < 4; b++) w[8*b +: 8] = page_byte(i * 4 + b, sum);
      push_result(KIND_PROG, '0, addr + 32'(4 * i), w, i == 0, i == PAGE_WORDS - 1);
    end
    live_slot = slot;
  endtask

  task automatic take_record_word(int idx, logic [2:0] slot, logic [31:0] data);
    int pos;
    if (slot >= SLOT_TOTAL || idx > CLOSE_IDX) return;
    if (idx == 0) begin
      cand_magic_ok = (data[15:0] == HDR_TAG);
      cand_seq      = data[31:16];
      cand_run_sum  = '0;
    end else if (idx == 1) begin
      cand_stored_sum = data[15:0];
    end else begin
      for (int b = 0; b < 4; b++) begin
        pos = (idx - 2) * 4 + b;
        if (pos < DATA_BYTES) begin
          staging[pos] = data[8*b +: 8];
          cand_run_sum = cand_run_sum + 16'(data[8*b +: 8]);
        end
      end
    end
    if (idx == CLOSE_IDX && cand_magic_ok && cand_stored_sum == cand_run_sum &&
        (best_seq == SEQ_NONE || {1'b0, cand_seq} > best_seq)) begin
      best_seq   = {1'b0, cand_seq};
      live_slot  = slot;
      commit_seq = cand_seq;
      shadow     = staging;
    end
  endtask

  task automatic predict_word(op_e op, logic [7:0] a, logic [15:0] wd, logic [2:0] slot,
                              logic [31:0] fd, logic fin);
    int  ai;
    bit  bit_ok;
    ai = int'(a);
    bit_ok = ai <= LAST_BIT && (ai >> 3) < DATA_BYTES;
    case (op)
      OP_RD8:
        push_result(KIND_READ, ai < DATA_BYTES ? {8'h00, shadow[ai]} : 16'h00FF,
                    '0, '0, 1'b0, 1'b1);
      OP_RD16:
        push_result(KIND_READ, ai + 2 <= DATA_BYTES ? {shadow[ai + 1], shadow[ai]} : 16'hFFFF,
                    '0, '0, 1'b0, 1'b1);
      OP_RDBIT:
        push_result(KIND_READ, bit_ok ? 16'(shadow[ai >> 3][ai & 7]) : 16'h0000,
                    '0, '0, 1'b0, 1'b1);
      OP_WR8:
        if (ai < DATA_BYTES) begin
          shadow[ai] = wd[7:0];
          program_page();
        end
      OP_WR16:
        if (ai + 2 <= DATA_BYTES) begin
          shadow[ai]     = wd[7:0];
          shadow[ai + 1] = wd[15:8];
          program_page();
        end
      OP_WRBIT:
        if (bit_ok) begin
          shadow[ai >> 3][ai & 7] = wd[0];
          program_page();
        end
      OP_START: clear_store();
      default: begin
        take_record_word(ai, slot, fd);
        if (fin) push_result(KIND_DONE, 16'(best_seq != SEQ_NONE), '0, '0, 1'b0, 1'b1);
      end
    endcase
  endtask

  // ---------------------------------------------------------------- stimulus helpers
  task automatic add_word(op_e op, logic [7:0] a, logic [15:0] wd, logic [2:0] slot,
                          logic [31:0] fd, logic fin);
    pend_t p;
    p.what = P_ITEM; p.op = op; p.addr = a; p.wdata = wd; p.slot = slot;
    p.fdata = fd; p.fin = fin; p.cfg = '0;
    pend_q.push_back(p);
  endtask

  task automatic add_marker(pend_kind_e what, logic [31:0] value);
    pend_t p;
    p = '{what: what, op: OP_RD8, addr: '0, wdata: '0, slot: '0, fdata: '0, fin: 1'b0,
          cfg: value};
    pend_q.push_back(p);
  endtask

  // Stream one record; flaw 0 clean, 1 bad magic, 2 bad sum, 3 a dropped word,
  // 4 two data words swapped (still accepted, contents moved). A short record
  // sends only the two header words and the closing word, keeping the rest of
  // staging as it is.
  task automatic add_record(logic [2:0] slot, logic [15:0] seq, int flaw, logic fin,
                            bit full);
    logic [31:0] words [CLOSE_IDX + 1];
    logic [15:0] sum;
    int          drop, swp, pos;
    logic [31:0] tmp;
    sum = '0;
    for (int i = 2; i <= CLOSE_IDX; i++) begin
      words[i] = $urandom;
      for (int b = 0; b < 4; b++) begin
        pos = (i - 2) * 4 + b;
        if (pos < DATA_BYTES && (full || i == CLOSE_IDX))
          sum = sum + 16'(words[i][8*b +: 8]);
      end
    end
    words[0] = {seq, flaw == 1 ? (HDR_TAG ^ 16'(1 << $urandom_range(0, 15))) : HDR_TAG};
    words[1] = {16'($urandom), flaw == 2 ? sum + 16'd1 : sum};
    drop = flaw == 3 ? $urandom_range(2, CLOSE_IDX - 1) : -1;
    swp  = flaw == 4 ? $urandom_range(2, CLOSE_IDX - 2) : -1;
    for (int i = 0; i <= CLOSE_IDX; i++) begin
      if (i == swp) begin
        tmp = words[i]; words[i] = words[i + 1]; words[i + 1] = tmp;
      end
      if (i != drop && (full || i < 2 || i == CLOSE_IDX))
        add_word(OP_RECW, 8'(i), 16'($urandom), slot, words[i], fin && i == CLOSE_IDX);
    end
  endtask

  task automatic add_random_word();
    int   r;
    logic [7:0] a;
    r = $urandom_range(0, 99);
    a = $urandom_range(0, 1) ? 8'($urandom) :
        ($urandom_range(0, 1) ? 8'($urandom_range(0, 15)) : 8'($urandom_range(232, 255)));
    if (r < 30)
      add_word(op_e'($urandom_range(0, 2)), a, 16'($urandom), 3'($urandom), $urandom, 1'b0);
    else if (r < 70)
      add_word(op_e'($urandom_range(3, 5)), a, 16'($urandom), 3'($urandom), $urandom, 1'b0);
    else if (r < 95)
      add_word(OP_RECW, 8'($urandom), 16'($urandom), 3'($urandom), $urandom,
               $urandom_range(0, 2) == 0);
    else
      add_word(OP_START, a, 16'($urandom), 3'($urandom), $urandom, 1'b0);
  endtask

  // A full scan: clear, a few short records of mixed quality, report on the last word
  task automatic add_scan();
    int n;
    add_word(OP_START, '0, '0, '0, '0, 1'b0);
    n = $urandom_range(2, 3);
    for (int k = 0; k < n; k++)
      add_record(3'($urandom_range(0, SLOT_TOTAL - 1)), 16'($urandom),
                 $urandom_range(0, 2) == 0 ? $urandom_range(1, 4) : 0, k == n - 1, 1'b0);
  endtask

  // ---------------------------------------------------------------- clock and reset
  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    rst_ni       = 1'b0;
    cfg_we_i     = 1'b0;
    cfg_wdata_i  = '0;
    in_if.valid  = 1'b0;
    in_if.op     = '0;
    in_if.addr   = '0;
    in_if.wdata  = '0;
    in_if.slot   = '0;
    in_if.flash_data = '0;
    in_if.final_req  = 1'b0;
    out_if.ready = 1'b0;
    in_took      = 1'b0;
    base_addr    = BASE_RESET;
    foreach (staging[i]) staging[i] = 8'h00;
    clear_store();
    repeat (10) @(negedge clk_i);
    rst_ni = 1'b1;
  end

  // ---------------------------------------------------------------- test plan
  initial begin
    // Addresses near the top wrap past 32 bits
    add_marker(P_CFG, 32'hFFFF_FF00);

    // Range edges of reads on the erased store
    add_word(OP_RD8,   8'd0,   '0, '0, '0, 1'b0);
    add_word(OP_RD8,   8'd240, '0, '0, '0, 1'b0);
    add_word(OP_RD16,  8'd255, '0, '0, '0, 1'b0);
    add_word(OP_RDBIT, 8'd255, '0, '0, '0, 1'b0);
    // Writes at both ends, and the ones that must be dropped
    add_word(OP_WR8,   8'd0,   16'hFF00, '0, '0, 1'b0);
    add_word(OP_WR8,   8'd239, 16'h00A5, '0, '0, 1'b0);
    add_word(OP_WR8,   8'd240, 16'h1234, '0, '0, 1'b0);
    add_word(OP_WR16,  8'd238, 16'hFFFF, '0, '0, 1'b0);
    add_word(OP_WR16,  8'd239, 16'h5A5A, '0, '0, 1'b0);
    add_word(OP_WRBIT, 8'd100, 16'hFFFF, '0, '0, 1'b0);
    add_word(OP_WRBIT, 8'd101, 16'h0001, '0, '0, 1'b0);
    add_word(OP_WRBIT, 8'd7,   16'hFFFE, '0, '0, 1'b0);
    add_word(OP_RD16,  8'd238, '0, '0, '0, 1'b0);
    add_word(OP_RD16,  8'd239, '0, '0, '0, 1'b0);
    add_word(OP_RD8,   8'd239, '0, '0, '0, 1'b0);
    add_word(OP_RDBIT, 8'd100, '0, '0, '0, 1'b0);
    add_word(OP_RDBIT, 8'd101, '0, '0, '0, 1'b0);
    add_word(OP_RDBIT, 8'd7,   '0, '0, '0, 1'b0);
    // Recovery: a clean record first so staging is filled, then the top sequence
    add_word(OP_START, '0, '0, '0, '0, 1'b0);
    add_record(3'd7, 16'hFFFE, 0, 1'b0, 1'b1);
    add_record(3'd2, 16'hFFFF, 0, 1'b0, 1'b0);
    add_record(3'd4, 16'h0003, 0, 1'b1, 1'b0);   // lower sequence loses
    add_word(OP_RD16, 8'd0, '0, '0, '0, 1'b0);
    add_word(OP_WR8,  8'd5, 16'h0042, '0, '0, 1'b0);  // sequence wraps to zero
    add_word(OP_START, '0, '0, '0, '0, 1'b0);
    add_word(OP_RECW, 8'd0, '0, 3'd7, 32'h0000_0000, 1'b1);  // nothing found

    add_marker(P_DRAIN, '0);
    add_marker(P_CFG, 32'h0000_0000);
    for (int i = 0; i < 25; i++) begin
      if (i == 12) add_scan();
      else add_random_word();
    end

    // Hold the sender until the block has drained completely
    add_marker(P_DRAIN, '0);
    add_marker(P_CFG, 32'hFFFF_FFFF);
    for (int i = 0; i < 20; i++) begin
      if (i == 8) add_scan();
      else add_random_word();
    end
    add_marker(P_DRAIN, '0);
    add_marker(P_CFG, $urandom);
    for (int i = 0; i < 8; i++) add_random_word();
    add_marker(P_DRAIN, '0);
    add_marker(P_CFG, BASE_RESET);
    for (int i = 0; i < 8; i++) add_random_word();

    wait (rst_ni);
    while (pend_q.size() > 0 || in_if.valid || expected_q.size() > 0) @(posedge clk_i);
    repeat (SETTLE) @(posedge clk_i);
    if (errors == 0 && expected_q.size() == 0)
      $display("end of test: clean");
    else
      $display("end of test: mismatches");
    $finish;
  end

  // ---------------------------------------------------------------- driver
  // Advance to the next pending word once the current one is taken; config
  // writes and drain points wait for an idle, settled block.
  always @(negedge clk_i) begin : drive_p
    logic  nv;
    logic  nwe;
    bit    settled;
    pend_t p;
    nv  = in_if.valid && !in_took;
    nwe = 1'b0;
    settled = expected_q.size() == 0 && quiet_cnt >= SETTLE;
    calm = pend_q.size() < 25;
    if (rst_ni && !nv) begin
      if (send_gap > 0) begin
        send_gap--;
      end else if (pend_q.size() > 0) begin
        p = pend_q[0];
        case (p.what)
          P_ITEM: begin
            void'(pend_q.pop_front());
            nv = 1'b1;
            in_if.op         <= p.op;
            in_if.addr       <= p.addr;
            in_if.wdata      <= p.wdata;
            in_if.slot       <= p.slot;
            in_if.flash_data <= p.fdata;
            in_if.final_req  <= p.fin;
            if (!calm && $urandom_range(0, 5) == 0) send_gap = $urandom_range(1, 16);
          end
          P_CFG: if (settled) begin
            void'(pend_q.pop_front());
            nwe = 1'b1;
            cfg_wdata_i <= p.cfg;
          end
          default: if (settled) void'(pend_q.pop_front());
        endcase
      end
    end
    in_if.valid <= nv;
    cfg_we_i    <= nwe;
  end

  // ---------------------------------------------------------------- receiver
  // One long hold once results flow, so the queue fills and the input stalls
  always @(negedge clk_i) begin : sink_p
    logic r;
    r = 1'b1;
    if (long_hold > 0) begin
      long_hold--;
      r = 1'b0;
    end else if (!held_once && out_cnt >= 100) begin
      held_once = 1;
      long_hold = 400;
      r = 1'b0;
    end else if (recv_gap > 0) begin
      recv_gap--;
      r = 1'b0;
    end else if (!calm && $urandom_range(0, 7) == 0) begin
      recv_gap = $urandom_range(1, 16);
      r = 1'b0;
    end
    out_if.ready <= rst_ni && r;
  end

  // ---------------------------------------------------------------- predict and check
  always @(posedge clk_i) begin : check_p
    result_t e;
    bit      in_fire;
    bit      out_fire;
    in_fire  = rst_ni && in_if.valid && in_if.ready;
    out_fire = rst_ni && out_if.valid && out_if.ready;
    in_took <= in_fire;
    if (rst_ni && cfg_we_i) base_addr = cfg_wdata_i;
    if (in_fire)
      predict_word(op_e'(in_if.op), in_if.addr, in_if.wdata, in_if.slot, in_if.flash_data,
                   in_if.final_req);
    if (out_fire) begin
      out_cnt++;
      if (expected_q.size() == 0) begin
        errors++;
        $display("%0t: unexpected word kind=%0d data=%h addr=%h word=%h", $time,
                 out_if.kind, out_if.read_data, out_if.flash_addr, out_if.page_word);
      end else begin
        e = expected_q.pop_front();
        if (out_if.kind !== e.kind || out_if.read_data !== e.rd ||
            out_if.flash_addr !== e.fa || out_if.page_word !== e.pw ||
            out_if.erase_first !== e.er || out_if.last !== e.last) begin
          errors++;
          $display("%0t: mismatch expected kind=%0d data=%h addr=%h word=%h erase=%b last=%b",
                   $time, e.kind, e.rd, e.fa, e.pw, e.er, e.last);
          $display("%0t:          actual   kind=%0d data=%h addr=%h word=%h erase=%b last=%b",
                   $time, out_if.kind, out_if.read_data, out_if.flash_addr,
                   out_if.page_word, out_if.erase_first, out_if.last);
        end
      end
    end
    // Settling: count idle cycles with nothing owed and nothing offered
    if (expected_q.size() == 0 && !in_if.valid && !in_fire && !out_fire) quiet_cnt++;
    else quiet_cnt = 0;
    // Watchdog: drop out if neither side moves for too long
    if (!rst_ni || in_fire || out_fire) stall_cnt = 0;
    else stall_cnt++;
    if (stall_cnt >= STALL_LIMIT) begin
      $display("end of test: mismatches");
      $finish;
    end
  end

endmodule

[files.f]
sv/fee_pkg.sv
sv/fee_if.sv
sv/fee_ram.sv
sv/fee_front.sv
sv/fee_queue.sv
sv/fee_back.sv
sv/flash_eeprom_emulator.sv
tb/sv/flash_eeprom_emulator_tb.sv
